>>> rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Shared types, token codes and lookup functions for the scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int CountBits    = 16;
  localparam int KeywordChars = 6;
  localparam int QueueDepth   = 4;
  localparam int QueueAw      = 2;

  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_NUMINT, M_NUMDOT, M_NUMFRAC, M_MINUS,
    M_BANG, M_EQ, M_LT, M_GT, M_STR, M_ESC
  } mode_t;

  localparam logic [5:0] K_END = 6'd0;
  localparam logic [5:0] K_ERR = 6'd1;
  localparam logic [5:0] K_IDENT = 6'd2;
  localparam logic [5:0] K_NUM = 6'd3;
  localparam logic [5:0] K_STR = 6'd4;
  localparam logic [5:0] K_SCHAR = 6'd5;
  localparam logic [5:0] K_DOT = 6'd16;
  localparam logic [5:0] K_ARROW = 6'd17;
  localparam logic [5:0] K_MINUS = 6'd18;
  localparam logic [5:0] K_NOTEQUAL = 6'd24;
  localparam logic [5:0] K_EQEQUAL = 6'd25;
  localparam logic [5:0] K_EQUAL = 6'd26;
  localparam logic [5:0] K_LESSEQUAL = 6'd27;
  localparam logic [5:0] K_LESS = 6'd28;
  localparam logic [5:0] K_GREATEREQUAL = 6'd29;
  localparam logic [5:0] K_GREATER = 6'd30;
  localparam logic [5:0] K_KW0 = 6'd31;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_UNEXP = 2'd1;
  localparam logic [1:0] E_UNTERM = 2'd2;
  localparam logic [1:0] E_ESCAPE = 2'd3;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic [7:0]  ch;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic       eoi;
    logic [7:0] c;
  } req_t;

  function automatic logic [15:0] clamp16(input count_t x);
    if (CountBits > 16 && x > count_t'(16'hFFFF)) return 16'hFFFF;
    return 16'(x);
  endfunction

  function automatic count_t sat_inc(input count_t x);
    return (x == '1) ? x : x + count_t'(1);
  endfunction

  function automatic logic [5:0] single_punct(input logic [7:0] c);
    case (c)
      "(": return 6'd6;  ")": return 6'd7;  "{": return 6'd8;
      "}": return 6'd9;  "[": return 6'd10; "]": return 6'd11;
      "?": return 6'd12; ":": return 6'd13; ";": return 6'd14;
      ",": return 6'd15; ".": return 6'd16; "+": return 6'd19;
      "/": return 6'd20; "%": return 6'd21; "*": return 6'd22;
      "^": return 6'd23;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [8:0] decode_escape(input logic [7:0] c);
    case (c)
      "\"": return 9'd34;
      "\\": return 9'd92;
      "b": return 9'd8;
      "n": return 9'd10;
      "r": return 9'd13;
      "f": return 9'd12;
      "t": return 9'd9;
      "v": return 9'd11;
      default: return 9'd256;
    endcase
  endfunction

  function automatic logic [5:0] kw_kind(input logic [8*KeywordChars-1:0] p,
                                         input count_t n);
    logic [47:0] w;
    w = 48'(p);
    if (n > count_t'(6)) return K_IDENT;
    case (w)
      48'h646e61:       return (n == 3) ? K_KW0 + 6'd0 : K_IDENT;
      48'h6b61657262:   return (n == 5) ? K_KW0 + 6'd1 : K_IDENT;
      48'h7373616c63:   return (n == 5) ? K_KW0 + 6'd2 : K_IDENT;
      48'h65736c65:     return (n == 4) ? K_KW0 + 6'd3 : K_IDENT;
      48'h65736c6166:   return (n == 5) ? K_KW0 + 6'd4 : K_IDENT;
      48'h6e66:         return (n == 2) ? K_KW0 + 6'd5 : K_IDENT;
      48'h726f66:       return (n == 3) ? K_KW0 + 6'd6 : K_IDENT;
      48'h6669:         return (n == 2) ? K_KW0 + 6'd7 : K_IDENT;
      48'h7478656e:     return (n == 4) ? K_KW0 + 6'd8 : K_IDENT;
      48'h746f6e:       return (n == 3) ? K_KW0 + 6'd9 : K_IDENT;
      48'h6c6c756e:     return (n == 4) ? K_KW0 + 6'd10 : K_IDENT;
      48'h726f:         return (n == 2) ? K_KW0 + 6'd11 : K_IDENT;
      48'h6e7275746572: return (n == 6) ? K_KW0 + 6'd12 : K_IDENT;
      48'h7265707573:   return (n == 5) ? K_KW0 + 6'd13 : K_IDENT;
      48'h686374697773: return (n == 6) ? K_KW0 + 6'd14 : K_IDENT;
      48'h73696874:     return (n == 4) ? K_KW0 + 6'd15 : K_IDENT;
      48'h65757274:     return (n == 4) ? K_KW0 + 6'd16 : K_IDENT;
      48'h726176:       return (n == 3) ? K_KW0 + 6'd17 : K_IDENT;
      48'h6e656877:     return (n == 4) ? K_KW0 + 6'd18 : K_IDENT;
      48'h656c696877:   return (n == 5) ? K_KW0 + 6'd19 : K_IDENT;
      default:          return K_IDENT;
    endcase
  endfunction

endpackage

>>> rtl/sts_front.sv
// ----------------------------------------------------------------------------
// Token scanner front end
// Accepts source requests and places them in a short queue.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       q_valid,
  input  logic       q_pop,
  output req_t       q_data
);

  req_t mem [QueueDepth];
  logic [QueueAw-1:0] wptr, rptr;
  logic [QueueAw:0] fill;
  logic push;

  assign in_stall = (fill == (QueueAw+1)'(QueueDepth));
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != '0);
  assign q_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{eoi: end_of_input, c: in_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      fill <= fill + (QueueAw+1)'(push) - (QueueAw+1)'(q_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    fill <= (QueueAw+1)'(QueueDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> fill == $past(fill) + 1'b1)
    else $error("fill count slip");

endmodule

>>> rtl/sts_back.sv
// ----------------------------------------------------------------------------
// Token scanner back end
// Scans a request per cycle unless stalled; buffers and drains up to 3 tokens.
// ----------------------------------------------------------------------------
module sts_back import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  req_t        q_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tok_t        out_tok
);

  mode_t  mode, mode_next;
  count_t line, line_next, col, col_next, lexlen, lexlen_next, held, held_next;
  logic [8*KeywordChars-1:0] kwp, kwp_next;

  tok_t   res [3];
  logic [1:0] nres;

  tok_t   buf_tok [3];
  logic [1:0] buf_n, buf_i;
  logic   buf_full;

  logic [7:0] c;
  logic alpha, digit, go, flushed, pend;
  logic [5:0] pk;
  logic [7:0] second;
  logic [8:0] d;

  assign c = q_data.c;
  assign alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  assign digit = c >= "0" && c <= "9";

  assign buf_full = (buf_n != 2'd0);
  assign go = q_valid && (!buf_full || (buf_i == buf_n - 2'd1 && !out_stall));
  assign q_pop = go;

  always_comb begin
    tok_t t;
    mode_next = mode; line_next = line; col_next = col;
    lexlen_next = lexlen; kwp_next = kwp; held_next = held;
    nres = 2'd0; res[0] = '0; res[1] = '0; res[2] = '0;
    flushed = 1'b0; pend = 1'b0; pk = '0; second = '0; d = '0;
    t = '0;
    if (q_data.eoi) begin
      flushed = 1'b1;
    end else begin
      case (mode)
        M_COMMENT: begin
          if (c == 8'h0a) pend = 1'b1;
          else col_next = sat_inc(col);
        end
        M_IDENT: begin
          if (alpha || digit) begin
            for (int i = 0; i < KeywordChars; i++)
              if (lexlen == count_t'(i)) kwp_next[8*i +: 8] = c;
            col_next = sat_inc(col); lexlen_next = sat_inc(lexlen);
          end else flushed = 1'b1;
        end
        M_NUMINT: begin
          if (digit) begin
            col_next = sat_inc(col); lexlen_next = sat_inc(lexlen);
          end else if (c == ".") begin
            held_next = col; col_next = sat_inc(col);
            lexlen_next = sat_inc(lexlen); mode_next = M_NUMDOT;
          end else flushed = 1'b1;
        end
        M_NUMDOT, M_NUMFRAC: begin
          if (digit) begin
            col_next = sat_inc(col); lexlen_next = sat_inc(lexlen);
            mode_next = M_NUMFRAC;
          end else flushed = 1'b1;
        end
        M_MINUS, M_BANG, M_EQ, M_LT, M_GT: begin
          case (mode)
            M_MINUS: begin second = ">"; pk = K_ARROW; end
            M_BANG:  begin second = "="; pk = K_NOTEQUAL; end
            M_EQ:    begin second = "="; pk = K_EQEQUAL; end
            M_LT:    begin second = "="; pk = K_LESSEQUAL; end
            default: begin second = "="; pk = K_GREATEREQUAL; end
          endcase
          if (c == second) begin
            col_next = sat_inc(col); lexlen_next = sat_inc(lexlen);
            res[0] = '{kind: pk, err: E_NONE, len: clamp16(lexlen_next),
                       line: clamp16(line), col: clamp16(col_next), ch: 8'd0,
                       last: 1'b0};
            nres = 2'd1; mode_next = M_IDLE;
          end else flushed = 1'b1;
        end
        M_STR: begin
          col_next = sat_inc(col); lexlen_next = sat_inc(lexlen);
          if (c == "\"") begin
            res[0] = '{kind: K_STR, err: E_NONE, len: clamp16(lexlen_next),
                       line: clamp16(line), col: clamp16(col_next), ch: 8'd0,
                       last: 1'b0};
            nres = 2'd1; mode_next = M_IDLE;
          end else if (c == "\\") begin
            mode_next = M_ESC;
          end else begin
            if (c == 8'h0a || c == 8'h0d) begin
              line_next = sat_inc(line); col_next = '0;
            end
            res[0] = '{kind: K_SCHAR, err: E_NONE, len: 16'd1,
                       line: clamp16(line_next), col: clamp16(col_next), ch: c,
                       last: 1'b0};
            nres = 2'd1;
          end
        end
        M_ESC: begin
          col_next = sat_inc(col); lexlen_next = sat_inc(lexlen);
          d = decode_escape(c);
          if (!d[8]) begin
            res[0] = '{kind: K_SCHAR, err: E_NONE, len: 16'd2,
                       line: clamp16(line), col: clamp16(col_next), ch: d[7:0],
                       last: 1'b0};
            mode_next = M_STR;
          end else begin
            res[0] = '{kind: K_ERR, err: E_ESCAPE, len: clamp16(lexlen_next),
                       line: clamp16(line), col: clamp16(col_next), ch: 8'd0,
                       last: 1'b0};
            mode_next = M_IDLE;
          end
          nres = 2'd1;
        end
        default: pend = 1'b1;
      endcase
    end
    if (flushed) begin
      t = '{kind: K_ERR, err: E_NONE, len: clamp16(lexlen), line: clamp16(line),
            col: clamp16(col), ch: 8'd0, last: 1'b0};
      case (mode)
        M_IDENT: t.kind = kw_kind(kwp, lexlen);
        M_NUMINT, M_NUMFRAC: t.kind = K_NUM;
        M_NUMDOT: begin
          res[nres] = '{kind: K_NUM, err: E_NONE, len: clamp16(lexlen - 1'b1),
                        line: clamp16(line), col: clamp16(held), ch: 8'd0,
                        last: 1'b0};
          nres = nres + 2'd1;
          t.kind = K_DOT; t.len = 16'd1;
        end
        M_MINUS: begin t.kind = K_MINUS; t.len = 16'd1; end
        M_BANG: begin t.err = E_UNEXP; t.len = 16'd1; end
        M_EQ: begin t.kind = K_EQUAL; t.len = 16'd1; end
        M_LT: begin t.kind = K_LESS; t.len = 16'd1; end
        M_GT: begin t.kind = K_GREATER; t.len = 16'd1; end
        M_STR: t.err = E_UNTERM;
        M_ESC: t.err = E_ESCAPE;
        default: t.kind = K_END;
      endcase
      if (mode != M_IDLE && mode != M_COMMENT) begin
        res[nres] = t; nres = nres + 2'd1;
      end
      mode_next = M_IDLE;
      if (q_data.eoi) begin
        lexlen_next = '0; kwp_next = '0;
        res[nres] = '{kind: K_END, err: E_NONE, len: 16'd0, line: clamp16(line),
                      col: clamp16(col), ch: 8'd0, last: 1'b0};
        nres = nres + 2'd1;
      end else pend = 1'b1;
    end
    if (pend) begin
      mode_next = M_IDLE; lexlen_next = '0; kwp_next = '0;
      if (c == 8'h0a) begin
        line_next = sat_inc(line); col_next = '0;
      end else begin
        col_next = sat_inc(col);
        if (!(c == " " || c == 8'h09 || c == 8'h0d)) begin
          lexlen_next = count_t'(1);
          if (c == "#") mode_next = M_COMMENT;
          else if (alpha) begin
            kwp_next = '0; kwp_next[7:0] = c; mode_next = M_IDENT;
          end
          else if (digit) mode_next = M_NUMINT;
          else if (c == "\"") mode_next = M_STR;
          else if (c == "-") mode_next = M_MINUS;
          else if (c == "!") mode_next = M_BANG;
          else if (c == "=") mode_next = M_EQ;
          else if (c == "<") mode_next = M_LT;
          else if (c == ">") mode_next = M_GT;
          else begin
            res[nres] = '{kind: (single_punct(c) != 0) ? single_punct(c) : K_ERR,
                          err: (single_punct(c) != 0) ? E_NONE : E_UNEXP,
                          len: 16'd1, line: clamp16(line), col: clamp16(col_next),
                          ch: 8'd0, last: 1'b0};
            nres = nres + 2'd1;
          end
        end
      end
    end
    if (nres != 0) res[nres - 2'd1].last = 1'b1;
  end

  assign out_valid = buf_full;
  assign out_tok = buf_tok[buf_i];

  always_ff @(posedge clk) begin
    if (go) begin
      buf_tok[0] <= res[0];
      buf_tok[1] <= res[1];
      buf_tok[2] <= res[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; line <= count_t'(1); col <= '0; lexlen <= '0;
      kwp <= '0; held <= '0; buf_n <= '0; buf_i <= '0;
    end else begin
      if (go) begin
        mode <= mode_next; line <= line_next; col <= col_next;
        lexlen <= lexlen_next; kwp <= kwp_next; held <= held_next;
        buf_n <= nres; buf_i <= '0;
      end else if (buf_full && !out_stall) begin
        if (buf_i == buf_n - 2'd1) buf_n <= '0;
        else buf_i <= buf_i + 2'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> buf_i < buf_n)
    else $error("drain index past count");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_tok.last) |-> buf_i == buf_n - 2'd1)
    else $error("last flag misplaced");
  assert property (@(posedge clk) disable iff (rst) line != '0)
    else $error("line count zero");

endmodule

>>> rtl/script_token_scanner_core.sv
// ----------------------------------------------------------------------------
// Script token scanner
// Byte stream in, token stream out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one request, a source byte or an
// end-of-input marker. Output channel: out_valid/out_stall carry one token.
// A request gives zero to three tokens; last_of_run marks the final one.
// The front end queues up to four requests; the back end scans one request
// per cycle when its three-entry token buffer is free or about to be.
// A request is registered in the queue, then its tokens in the token buffer.
// Throughput is one request per cycle while each gives at most one token
// and out_stall is low; a request with n tokens drains them one by one.
// Reset (synchronous, active high) empties the queue and buffer and sets
// line 1, column 0, scanner idle. When the receiver stalls, the token shown
// holds, the buffer stays full, and the queue fills and stalls the sender.
// ----------------------------------------------------------------------------
module script_token_scanner_core import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [1:0]  error_code,
  output logic [15:0] token_length,
  output logic [15:0] token_line,
  output logic [15:0] token_column,
  output logic [7:0]  string_char,
  output logic        last_of_run
);

  logic q_valid, q_pop;
  req_t q_data;
  tok_t tok;

  sts_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_byte, .end_of_input,
    .q_valid, .q_pop, .q_data
  );

  sts_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data, .out_valid, .out_stall,
    .out_tok(tok)
  );

  assign token_kind = tok.kind;
  assign error_code = tok.err;
  assign token_length = tok.len;
  assign token_line = tok.line;
  assign token_column = tok.col;
  assign string_char = tok.ch;
  assign last_of_run = tok.last;

endmodule
